>>> sv/value_stack_with_removal_macros.svh
// Assertion helpers for the value stack. All checks are clocked on clk and
// held off while rst is high.
`ifndef VALUE_STACK_WITH_REMOVAL_MACROS_SVH
`define VALUE_STACK_WITH_REMOVAL_MACROS_SVH

// Same-cycle implication.
`define VSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/vsr_pkg.sv
`timescale 1ns / 1ps

package vsr_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DATA_WIDTH  = 8;

  // count holds 0..STACK_DEPTH, an address holds 0..STACK_DEPTH-1
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

  localparam logic [2:0] ACT_PUSH       = 3'd0;
  localparam logic [2:0] ACT_POP        = 3'd1;
  localparam logic [2:0] ACT_REMOVE_ONE = 3'd2;
  localparam logic [2:0] ACT_REMOVE_ALL = 3'd3;
  localparam logic [2:0] ACT_FIND       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

>>> sv/value_stack_with_removal.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        sink       in_valid, in_stall   action, value
// out       source     out_valid, out_stall popped_value, found, removed_count,
//                                           stack_depth, top_value, status
//
// One item at a time; the entry array is a single RAM (one read, one write
// port, registered read), so find and removal walk the held entries one per cycle.
// Push, full push, empty actions and unknown codes go straight to the result register.
// Remove one walks down to the match, then shifts the rest down.
// rst is synchronous: the stack comes up empty, the RAM itself is not cleared.
// A stalled result stays in the output register; the next beat is taken meanwhile.

module value_stack_with_removal
  import vsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           action,
  input  logic [7:0]           value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           popped_value,
  output logic                 found,
  output logic [5:0]           removed_count,
  output logic [5:0]           stack_depth,
  output logic [7:0]           top_value,
  output logic [1:0]           status
);

  `include "value_stack_with_removal_macros.svh"

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_SHIFT   = 4'd2;
  localparam logic [3:0] S_COMPACT = 4'd3;
  localparam logic [3:0] S_TOP     = 4'd4;
  localparam logic [3:0] S_TOPW    = 4'd5;
  localparam logic [3:0] S_FINISH  = 4'd6;

  logic [3:0]            state;
  logic [CNT_W-1:0]      count;
  logic [DATA_WIDTH-1:0] top_q;

  logic [2:0]            act_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [DATA_WIDTH-1:0] popped_q;
  logic                  found_q;
  logic [CNT_W-1:0]      removed_q;
  logic [1:0]            status_q;

  logic [CNT_W-1:0]      ptr;
  logic [CNT_W-1:0]      pidx;
  logic [CNT_W-1:0]      kept;
  logic                  pend;

  logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;

  logic [DATA_WIDTH+7:0] val_ext;
  logic [DATA_WIDTH-1:0] val_in;
  logic [DATA_WIDTH+7:0] top_ext;
  logic [DATA_WIDTH+7:0] pop_ext;
  logic [CNT_W+5:0]      rem_ext;
  logic [CNT_W+5:0]      cnt_ext;

  logic [CNT_W-1:0]      ptr_dec;
  logic [CNT_W-1:0]      pidx_dec;
  logic [CNT_W-1:0]      count_dec;
  logic [CNT_W-1:0]      walked;
  logic                  match;
  logic                  hit;
  logic                  scan_issue;
  logic                  shift_issue;
  logic                  comp_issue;
  logic                  accept;
  logic                  is_full;
  logic                  is_empty;
  logic                  out_load;
  logic                  push_ok;
  logic                  pop_ok;
  logic [3:0]            idle_state;
  logic [1:0]            idle_status;

  assign val_ext   = {{DATA_WIDTH{1'b0}}, value};
  assign val_in    = val_ext[DATA_WIDTH-1:0];

  assign ptr_dec   = ptr - CNT_W'(1);
  assign pidx_dec  = pidx - CNT_W'(1);
  assign count_dec = count - CNT_W'(1);
  assign walked    = ptr - CNT_W'(pend);

  assign match       = (rd_data == val_q);
  assign hit         = pend && match;
  assign scan_issue  = (state == S_SCAN) && (ptr != '0) && !hit;
  assign shift_issue = (state == S_SHIFT) && (ptr < count);
  assign comp_issue  = (state == S_COMPACT) && (ptr < count);

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_full  = (count == FULL_CNT);
  assign is_empty = (count == '0);
  assign out_load = (state == S_FINISH) && (!out_valid || !out_stall);
  assign push_ok  = (action == ACT_PUSH) && !is_full;
  assign pop_ok   = (action == ACT_POP) && !is_empty;

  // where a new beat goes and what it reports up front
  always_comb begin
    idle_state  = S_FINISH;
    idle_status = ST_OK;
    case (action)
      ACT_PUSH: begin
        if (is_full) begin
          idle_status = ST_FULL;
        end
      end
      ACT_POP: begin
        if (is_empty) begin
          idle_status = ST_EMPTY;
        end else begin
          idle_state = S_TOP;
        end
      end
      ACT_REMOVE_ONE: begin
        if (is_empty) begin
          idle_status = ST_EMPTY;
        end else begin
          idle_state = S_SCAN;
        end
      end
      ACT_REMOVE_ALL: begin
        if (is_empty) begin
          idle_status = ST_EMPTY;
        end else begin
          idle_state = S_COMPACT;
        end
      end
      ACT_FIND: begin
        if (!is_empty) begin
          idle_state = S_SCAN;
        end
      end
      default: begin
        idle_state = S_FINISH;
      end
    endcase
  end

  // RAM port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = ptr[ADDR_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = count[ADDR_W-1:0];
    mem_wdata = val_in;
    case (state)
      S_IDLE: begin
        mem_we = accept && push_ok;
      end
      S_SCAN: begin
        mem_re    = scan_issue;
        mem_raddr = ptr_dec[ADDR_W-1:0];
      end
      S_SHIFT: begin
        mem_re    = shift_issue;
        mem_we    = pend;
        mem_waddr = pidx_dec[ADDR_W-1:0];
        mem_wdata = rd_data;
      end
      S_COMPACT: begin
        mem_re    = comp_issue;
        mem_we    = pend && !match;
        mem_waddr = kept[ADDR_W-1:0];
        mem_wdata = rd_data;
      end
      S_TOP: begin
        mem_re    = !is_empty;
        mem_raddr = count_dec[ADDR_W-1:0];
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      top_q     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            act_q     <= action;
            val_q     <= val_in;
            popped_q  <= pop_ok ? top_q : '0;
            found_q   <= 1'b0;
            removed_q <= '0;
            status_q  <= idle_status;
            pend      <= 1'b0;
            ptr       <= (action == ACT_REMOVE_ALL) ? '0 : count;
            kept      <= '0;
            state     <= idle_state;
            if (push_ok) begin
              count <= count + CNT_W'(1);
              top_q <= val_in;
            end else if (pop_ok) begin
              count <= count_dec;
            end
          end
        end
        // walk down from the top; first hit is the topmost match
        S_SCAN: begin
          if (hit) begin
            found_q <= 1'b1;
            pend    <= 1'b0;
            if (act_q == ACT_REMOVE_ONE) begin
              removed_q <= CNT_W'(1);
              ptr       <= pidx + CNT_W'(1);
              state     <= S_SHIFT;
            end else begin
              state <= S_FINISH;
            end
          end else if ((ptr == '0) && !pend) begin
            state <= S_FINISH;
          end else begin
            pend <= scan_issue;
            if (scan_issue) begin
              ptr  <= ptr_dec;
              pidx <= ptr_dec;
            end
          end
        end
        // move the entries above the hit down by one
        S_SHIFT: begin
          pend <= shift_issue;
          if (shift_issue) begin
            ptr  <= ptr + CNT_W'(1);
            pidx <= ptr;
          end
          if (!shift_issue && !pend) begin
            count <= count_dec;
            state <= S_TOP;
          end
        end
        // bottom-up: keepers are written back at the kept index
        S_COMPACT: begin
          pend <= comp_issue;
          if (comp_issue) begin
            ptr <= ptr + CNT_W'(1);
          end
          if (pend) begin
            if (match) begin
              removed_q <= removed_q + CNT_W'(1);
            end else begin
              kept <= kept + CNT_W'(1);
            end
          end
          if (!comp_issue && !pend) begin
            count   <= kept;
            found_q <= (removed_q != '0);
            state   <= S_TOP;
          end
        end
        S_TOP: begin
          if (is_empty) begin
            top_q <= '0;
            state <= S_FINISH;
          end else begin
            state <= S_TOPW;
          end
        end
        S_TOPW: begin
          top_q <= rd_data;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign top_ext = {8'b0, top_q};
  assign pop_ext = {8'b0, popped_q};
  assign rem_ext = {6'b0, removed_q};
  assign cnt_ext = {6'b0, count};

  // result register, loaded once the current beat has left
  always_ff @(posedge clk) begin
    if (out_load) begin
      popped_value  <= pop_ext[7:0];
      found         <= found_q;
      removed_count <= rem_ext[5:0];
      stack_depth   <= cnt_ext[5:0];
      top_value     <= top_ext[7:0];
      status        <= status_q;
    end
  end

  `VSR_ASSERT_IMP(a_count_bound, 1'b1, count <= FULL_CNT, "count above depth")
  `VSR_ASSERT_IMP(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "RAM clash")
  `VSR_ASSERT_IMP(a_read_held, mem_re, CNT_W'(mem_raddr) < count, "read past held entries")
  `VSR_ASSERT_IMP(a_compact_tally, state == S_COMPACT, (kept + removed_q) == walked, "tally lost")
  `VSR_ASSERT_IMP(a_empty_top, (state == S_IDLE) && (count == '0), top_q == '0, "empty, top set")
  `VSR_ASSERT_NXT(a_finish_leaves, out_load, out_valid && (state == S_IDLE), "result not sent")

endmodule
